/* rtl/assert_macros.svh */
// assertion macros used by the checker file of this project
// no dependencies; the including file supplies clock and reset signals
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLKD(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// clocked assertion that also holds across reset
`define ASSERT_CLKD_NORST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

/* rtl/psdf_pkg.sv */
// shared types and constants of the per-source duplicate filter
// no dependencies
`default_nettype none

package psdf_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int DEF_KEY_BITS      = 64;
   localparam int SOURCE_KEY_WIDTH  = 64;
   localparam int SEQ_WIDTH         = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } psdf_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the incoming word, restart the walk
      logic issue_read;  // read the table at the walk index
      logic write_seq;   // overwrite the sequence of the matching entry
      logic append;      // store the new source at the end of the table
      logic finish;      // capture the duplicate verdict
      logic load_rsp;    // move the verdict into the output register
   } psdf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_more;   // walk index below the used count
      logic key_hit;     // entry read last cycle holds this source
      logic seq_hit;     // last entry read holds this sequence
      logic full;        // every entry is in use
      logic out_free;    // output register can take a new word
   } psdf_status_type;

endpackage

`default_nettype wire

/* rtl/psdf_ctrl.sv */
// controller of the duplicate filter: accept, table walk, result hand-off
// depends on psdf_pkg
`default_nettype none

module psdf_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire psdf_pkg::psdf_status_type status,
   output psdf_pkg::psdf_cmd_type         cmd
);

   psdf_pkg::psdf_state_type state_ff;
   psdf_pkg::psdf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = psdf_pkg::ST_SCAN;
            end
         end
         psdf_pkg::ST_SCAN: begin
            if (status.key_hit || !status.scan_more) begin
               state_in = psdf_pkg::ST_DONE;
            end
         end
         psdf_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = psdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         psdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         psdf_pkg::ST_SCAN: begin
            if (status.key_hit) begin
               cmd.finish    = 1'b1;
               cmd.write_seq = !status.seq_hit;
            end else if (!status.scan_more) begin
               // source not in the table
               cmd.finish = 1'b1;
               cmd.append = !status.full;
            end else begin
               cmd.issue_read = 1'b1;
            end
         end
         psdf_pkg::ST_DONE: begin
            cmd.load_rsp = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/psdf_dpath.sv */
// datapath of the duplicate filter: source table, comparator, output register
// depends on psdf_pkg
`default_nettype none

module psdf_dpath #(
   parameter int TABLE_ENTRIES = psdf_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = psdf_pkg::DEF_KEY_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [psdf_pkg::SOURCE_KEY_WIDTH-1:0] req_source_key,
   input  wire logic [psdf_pkg::SEQ_WIDTH-1:0]        req_seq_number,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic                                       rsp_is_duplicate,
   input  wire psdf_pkg::psdf_cmd_type                cmd,
   output psdf_pkg::psdf_status_type                  status
);

   localparam int ADDR_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);

   // table storage, written at most once per item and read once per walk step
   logic [KEY_BITS-1:0]           key_mem_ff [TABLE_ENTRIES];
   logic [psdf_pkg::SEQ_WIDTH-1:0] seq_mem_ff [TABLE_ENTRIES];

   logic [KEY_BITS-1:0]            key_ff;
   logic [psdf_pkg::SEQ_WIDTH-1:0] seq_ff;
   logic [KEY_BITS-1:0]            rd_key_ff;
   logic [psdf_pkg::SEQ_WIDTH-1:0] rd_seq_ff;
   logic [ADDR_BITS-1:0]           cmp_idx_ff;
   logic [CNT_BITS-1:0]            idx_ff;
   logic [CNT_BITS-1:0]            idx_in;
   logic [CNT_BITS-1:0]            used_ff;
   logic [CNT_BITS-1:0]            used_in;
   logic                           cmp_valid_ff;
   logic                           result_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_dup_ff;
   logic [ADDR_BITS-1:0]           wr_addr;
   logic                           wr_en;

   assign wr_en   = cmd.write_seq || cmd.append;
   assign wr_addr = cmd.append ? used_ff[ADDR_BITS-1:0] : cmp_idx_ff;

   assign status.scan_more = (idx_ff < used_ff);
   assign status.key_hit   = cmp_valid_ff && (rd_key_ff == key_ff);
   assign status.seq_hit   = (rd_seq_ff == seq_ff);
   assign status.full      = (used_ff == CNT_BITS'(TABLE_ENTRIES));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.issue_read) begin
         idx_in = idx_ff + CNT_BITS'(1);
      end
   end

   assign used_in = cmd.append ? used_ff + CNT_BITS'(1) : used_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmd.issue_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_source_key[KEY_BITS-1:0];
         seq_ff <= req_seq_number;
      end
      if (cmd.issue_read) begin
         cmp_idx_ff <= idx_ff[ADDR_BITS-1:0];
      end
      if (cmd.finish) begin
         result_ff <= status.key_hit && status.seq_hit;
      end
      if (cmd.load_rsp) begin
         rsp_dup_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_read) begin
         rd_key_ff <= key_mem_ff[idx_ff[ADDR_BITS-1:0]];
         rd_seq_ff <= seq_mem_ff[idx_ff[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem_ff[wr_addr] <= seq_ff;
      end
      if (cmd.append) begin
         key_mem_ff[wr_addr] <= key_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;

endmodule

`default_nettype wire

/* rtl/per_source_duplicate_filter_core.sv */
// top level of the per-source duplicate sequence filter
// depends on psdf_pkg, psdf_ctrl and psdf_dpath
//
//   channel  ports                                    direction
//   req      req_valid req_ready req_source_key        in  (source key, sequence)
//            req_seq_number
//   rsp      rsp_valid rsp_ready rsp_is_duplicate      out (one word per req word)
//
// a word is taken only in the idle state; the walk then reads one table entry
// per cycle through the registered memory port and compares it the cycle after
// after acceptance an item walks the used entries, at most TABLE_ENTRIES of them, and
// when rsp is not stalled the next word can be accepted once its verdict is handed off
// a hit at entry j ends the walk early, without reading the entries after it
// reset clears the used count and all control; table contents need no clearing
// a stalled rsp holds in the output register while the next req word is taken
`default_nettype none

module per_source_duplicate_filter_core #(
   parameter int TABLE_ENTRIES = psdf_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = psdf_pkg::DEF_KEY_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [psdf_pkg::SOURCE_KEY_WIDTH-1:0] req_source_key,
   input  wire logic [psdf_pkg::SEQ_WIDTH-1:0]        req_seq_number,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_is_duplicate
);

   // command and status between the controller and the datapath
   psdf_pkg::psdf_cmd_type    cmd;
   psdf_pkg::psdf_status_type status;

   // state machine: idle, table walk, result hand-off
   psdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memory, used count, walk index, comparator and output register
   psdf_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_source_key   (req_source_key),
      .req_seq_number   (req_seq_number),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_is_duplicate (rsp_is_duplicate),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

/* rtl/psdf_checker.sv */
// port-level checks of the duplicate filter, bound to the top level
// depends on assert_macros.svh and per_source_duplicate_filter_core
`default_nettype none
`include "assert_macros.svh"

module psdf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_is_duplicate
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // words accepted on req but not yet delivered on rsp
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_CLKD_NORST(a_rsp_idle_after_reset, reset |=> !rsp_valid)
   `ASSERT_CLKD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_duplicate))
   `ASSERT_CLKD(a_no_extra_rsp, rsp_acc |-> pending_ff != 2'd0)
   `ASSERT_CLKD(a_bounded_backlog, pending_ff != 2'd3)
   `ASSERT_CLKD(a_one_at_a_time, req_acc |=> !req_ready)

endmodule

bind per_source_duplicate_filter_core psdf_checker u_psdf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_is_duplicate (rsp_is_duplicate)
);

`default_nettype wire
